FILE: hdl/stald_pkg.sv
// Shared constants, register codes and controller/datapath types of the STA/LTA onset detector.
package stald_pkg;

  // Sizing of the sample ring and of the windows
  localparam int unsigned RING_DEPTH  = 128;
  localparam int unsigned SAMPLE_BITS = 10;
  localparam int unsigned SHORT_MAX   = 16;

  // Derived widths
  localparam int unsigned PTR_W       = $clog2(RING_DEPTH);
  localparam int unsigned LEN_W       = $clog2(RING_DEPTH + 1);
  localparam int unsigned SLEN_W      = $clog2(SHORT_MAX + 1);
  localparam int unsigned SHORT_SUM_W = $clog2(SHORT_MAX * ((1 << SAMPLE_BITS) - 1) + 1);
  localparam int unsigned LONG_SUM_W  = $clog2(RING_DEPTH * ((1 << SAMPLE_BITS) - 1) + 1);

  // Configuration register widths and reset values
  localparam int unsigned SHORT_LEN_W  = 5;
  localparam int unsigned LONG_LEN_W   = 8;
  localparam int unsigned THRESH_W     = 12;
  localparam int unsigned CFG_DATA_W   = 12;
  localparam int unsigned CFG_ADDR_W   = 2;
  localparam logic [SHORT_LEN_W-1:0] SHORT_LEN_RST = SHORT_LEN_W'(5);
  localparam logic [LONG_LEN_W-1:0]  LONG_LEN_RST  = LONG_LEN_W'(75);
  localparam logic [THRESH_W-1:0]    THRESH_RST    = THRESH_W'(192);

  // Product widths for the cross-multiplied ratio compare
  localparam int unsigned FRAC_BITS = 4;
  localparam int unsigned SL_W      = SHORT_SUM_W + LEN_W;
  localparam int unsigned TL_W      = THRESH_W + LONG_SUM_W;
  localparam int unsigned RHS_W     = TL_W + SLEN_W;
  localparam int unsigned CMP_W     = (SL_W + FRAC_BITS > RHS_W) ? SL_W + FRAC_BITS : RHS_W;

  // Stream word widths
  localparam int unsigned IN_TDATA_W   = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int unsigned OUT_FIELDS_W = 2 + SHORT_SUM_W + LONG_SUM_W;
  localparam int unsigned OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  // Configuration register indexes
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_SHORT_LEN = 2'd0,
    REG_LONG_LEN  = 2'd1,
    REG_THRESHOLD = 2'd2
  } reg_idx_e;

  // Controller states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_UPDATE,
    ST_MUL,
    ST_MUL2,
    ST_FINISH
  } state_e;

  // Commands from controller to datapath
  typedef struct packed {
    logic accept;
    logic update;
    logic mul;
    logic mul2;
    logic finish;
  } cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic result_ok;
    logic out_free;
  } sts_t;

endpackage

FILE: hdl/stald_ctrl.sv
// Controller state machine sequencing one sample through ring update, multiplies and compare.
module stald_ctrl import stald_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    s_tready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd_o.update = 1'b1;
        state_d      = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        // no result while the long window fills or its sum is zero
        state_d = sts_i.result_ok ? ST_MUL2 : ST_IDLE;
      end
      ST_MUL2: begin
        cmd_o.mul2 = 1'b1;
        state_d    = ST_FINISH;
      end
      ST_FINISH: begin
        if (sts_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d      = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // At most one datapath command per cycle
  a_cmd_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(cmd_o)) else $error("more than one datapath command");

  // A result is only loaded into a free output register
  a_finish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |-> sts_i.out_free) else $error("result loaded over a pending word");

  // The update step always follows an accepted word
  a_accept_update: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.accept |=> cmd_o.update) else $error("accepted word not followed by update");

endmodule

FILE: hdl/stald_dp.sv
// Datapath: configuration registers, sample ring, running window sums, ratio compare and output.
module stald_dp import stald_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]  cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  input  cmd_t                   cmd_i,
  output sts_t                   sts_o,
  input  logic                   m_tready_i,
  output logic                   m_tvalid_o,
  output logic                   onset_o,
  output logic                   above_o,
  output logic [SHORT_SUM_W-1:0] short_sum_o,
  output logic [LONG_SUM_W-1:0]  long_sum_o
);

  // Long window length saturated to 2..RING_DEPTH
  function automatic logic [LEN_W-1:0] eff_long(input logic [LONG_LEN_W-1:0] len);
    logic [31:0] v;
    v = 32'(len);
    if (v < 32'd2) v = 32'd2;
    if (v > 32'(RING_DEPTH)) v = 32'(RING_DEPTH);
    return LEN_W'(v);
  endfunction

  // Short window length saturated to 1..SHORT_MAX, then to the long length
  function automatic logic [SLEN_W-1:0] eff_short(input logic [SHORT_LEN_W-1:0] len,
                                                  input logic [LEN_W-1:0] lng);
    logic [31:0] v;
    v = 32'(len);
    if (v < 32'd1) v = 32'd1;
    if (v > 32'(SHORT_MAX)) v = 32'(SHORT_MAX);
    if (v > 32'(lng)) v = 32'(lng);
    return SLEN_W'(v);
  endfunction

  // Ring slot n words behind the write pointer
  function automatic logic [PTR_W-1:0] back_slot(input logic [PTR_W-1:0] wp,
                                                 input logic [LEN_W-1:0] n);
    logic [LEN_W:0] w;
    logic [LEN_W:0] d;
    w = (LEN_W + 1)'(wp);
    d = (LEN_W + 1)'(n);
    if (w >= d) begin
      w = w - d;
    end else begin
      w = w + (LEN_W + 1)'(RING_DEPTH) - d;
    end
    return PTR_W'(w);
  endfunction

  logic [SHORT_LEN_W-1:0] short_len_q;
  logic [LONG_LEN_W-1:0]  long_len_q;
  logic [THRESH_W-1:0]    thresh_q;
  logic                   restart;

  logic [LEN_W-1:0]       len_l;
  logic [SLEN_W-1:0]      len_s;

  logic [SAMPLE_BITS-1:0] ring_mem [RING_DEPTH];
  logic [SAMPLE_BITS-1:0] x_q;
  logic [SAMPLE_BITS-1:0] old_s_q;
  logic [SAMPLE_BITS-1:0] old_l_q;

  logic [PTR_W-1:0]       wp_q;
  logic [LEN_W-1:0]       fill_q;
  logic [SHORT_SUM_W-1:0] short_tot_q, short_tot_d;
  logic [LONG_SUM_W-1:0]  long_tot_q, long_tot_d;
  logic                   in_event_q;

  logic [SL_W-1:0]        sl_prod;
  logic [TL_W-1:0]        tl_prod;
  logic [CMP_W-1:0]       lhs_q;
  logic [TL_W-1:0]        tl_q;
  logic [CMP_W-1:0]       rhs_q;
  logic                   above;

  logic                   m_tvalid_q;
  logic                   onset_q;
  logic                   above_q;
  logic [SHORT_SUM_W-1:0] short_out_q;
  logic [LONG_SUM_W-1:0]  long_out_q;

  // Configuration registers; a length write restarts the windows
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_len_q <= SHORT_LEN_RST;
      long_len_q  <= LONG_LEN_RST;
      thresh_q    <= THRESH_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_SHORT_LEN: short_len_q <= cfg_wdata_i[SHORT_LEN_W-1:0];
        REG_LONG_LEN:  long_len_q  <= cfg_wdata_i[LONG_LEN_W-1:0];
        REG_THRESHOLD: thresh_q    <= cfg_wdata_i[THRESH_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = cfg_we_i &&
                   (cfg_addr_i == REG_SHORT_LEN || cfg_addr_i == REG_LONG_LEN);
  assign len_l   = eff_long(long_len_q);
  assign len_s   = eff_short(short_len_q, len_l);

  // Sample ring: two reads on accept, one write on update
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      old_s_q <= ring_mem[back_slot(wp_q, LEN_W'(len_s))];
      old_l_q <= ring_mem[back_slot(wp_q, len_l)];
    end
    if (cmd_i.update) begin
      ring_mem[wp_q] <= x_q;
    end
  end

  // Incoming sample held for the update step
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      x_q <= sample_i;
    end
  end

  // Running sums: drop the word leaving each window, add the new one
  always_comb begin
    short_tot_d = short_tot_q + SHORT_SUM_W'(x_q);
    long_tot_d  = long_tot_q + LONG_SUM_W'(x_q);
    if (32'(fill_q) >= 32'(len_s)) short_tot_d = short_tot_d - SHORT_SUM_W'(old_s_q);
    if (fill_q >= len_l) long_tot_d = long_tot_d - LONG_SUM_W'(old_l_q);
  end

  // Window state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q        <= '0;
      fill_q      <= '0;
      short_tot_q <= '0;
      long_tot_q  <= '0;
      in_event_q  <= 1'b0;
    end else if (restart) begin
      wp_q        <= '0;
      fill_q      <= '0;
      short_tot_q <= '0;
      long_tot_q  <= '0;
      in_event_q  <= 1'b0;
    end else begin
      if (cmd_i.update) begin
        wp_q        <= (32'(wp_q) == RING_DEPTH - 1) ? '0 : wp_q + PTR_W'(1);
        short_tot_q <= short_tot_d;
        long_tot_q  <= long_tot_d;
        if (fill_q < len_l) fill_q <= fill_q + LEN_W'(1);
      end
      if (cmd_i.finish) begin
        in_event_q <= above;
      end
    end
  end

  // Ratio compare: short_sum * L * 16 against threshold * long_sum * S
  assign sl_prod = SL_W'(short_tot_q) * SL_W'(len_l);
  assign tl_prod = TL_W'(thresh_q) * TL_W'(long_tot_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      lhs_q <= CMP_W'({sl_prod, {FRAC_BITS{1'b0}}});
      tl_q  <= tl_prod;
    end
    if (cmd_i.mul2) begin
      rhs_q <= CMP_W'(RHS_W'(tl_q) * RHS_W'(len_s));
    end
  end

  assign above = lhs_q > rhs_q;

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_tvalid_q <= 1'b0;
    end else if (cmd_i.finish) begin
      m_tvalid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_tvalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish) begin
      onset_q     <= above & ~in_event_q;
      above_q     <= above;
      short_out_q <= short_tot_q;
      long_out_q  <= long_tot_q;
    end
  end

  assign sts_o.result_ok = (fill_q >= len_l) && (long_tot_q != '0);
  assign sts_o.out_free  = ~m_tvalid_q | m_tready_i;

  assign m_tvalid_o  = m_tvalid_q;
  assign onset_o     = onset_q;
  assign above_o     = above_q;
  assign short_sum_o = short_out_q;
  assign long_sum_o  = long_out_q;

  // The short window is never longer than the long one
  a_sum_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    long_tot_q >= LONG_SUM_W'(short_tot_q)) else $error("short sum exceeds long sum");

  // An onset word always reports the ratio above the threshold
  a_onset_above: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_q && onset_q |-> above_q) else $error("onset without crossing");

  // Fill count never passes the long window length
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= len_l) else $error("fill count beyond long window");

  // A finished word marks the event latch
  a_event_set: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.finish && above |=> in_event_q) else $error("event latch not set");

endmodule

FILE: hdl/sta_lta_onset_detector.sv
// Top level of the STA/LTA onset detector: stream ports, controller and datapath.
// A sample word is taken only in the idle state, so a new one waits until the last is through.
// Samples that give no result go back to idle after the first multiply step;
// the controller walks ring read, sum update and two multiply steps through one datapath.
// A pending result word that is not taken holds the next one in its last step.
// Reset (asynchronous, active low): registers to 5/75/192, windows empty; ring not cleared.
module sta_lta_onset_detector import stald_pkg::*; (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  // configuration writes
  input  logic                    cfg_we_i,
  input  logic [CFG_ADDR_W-1:0]   cfg_addr_i,
  input  logic [CFG_DATA_W-1:0]   cfg_wdata_i,
  // sample words
  input  logic                    s_tvalid_i,
  output logic                    s_tready_o,
  input  logic [IN_TDATA_W-1:0]   s_tdata_i,   // sample
  // result words
  output logic                    m_tvalid_o,
  input  logic                    m_tready_i,
  output logic [OUT_TDATA_W-1:0]  m_tdata_o    // onset, above_threshold, short_sum, long_sum
);

  cmd_t                   cmd;
  sts_t                   sts;
  logic                   onset;
  logic                   above;
  logic [SHORT_SUM_W-1:0] short_sum;
  logic [LONG_SUM_W-1:0]  long_sum;

  stald_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  stald_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .sample_i    (s_tdata_i[SAMPLE_BITS-1:0]),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .m_tready_i  (m_tready_i),
    .m_tvalid_o  (m_tvalid_o),
    .onset_o     (onset),
    .above_o     (above),
    .short_sum_o (short_sum),
    .long_sum_o  (long_sum)
  );

  // Pack result fields from the lowest bit up
  assign m_tdata_o = OUT_TDATA_W'({long_sum, short_sum, above, onset});

endmodule

FILE: bench/testbench.sv
// Scoreboard testbench for the STA/LTA onset detector: directed and random sample streams.
module testbench;
  import stald_pkg::*;

  localparam logic [CFG_ADDR_W-1:0] REG_UNUSED = CFG_ADDR_W'(3);
  localparam int unsigned IDLE_PCT     = 35;
  localparam int unsigned SETTLE       = 12;     // settling margin after the last awaited word
  localparam int unsigned RANDOM_ITEMS = 500;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned SHOW_MAX     = 10;

  // Result word as it sits in m_tdata, lowest field last
  typedef struct packed {
    logic [OUT_TDATA_W-OUT_FIELDS_W-1:0] pad;
    logic [LONG_SUM_W-1:0]               long_sum;
    logic [SHORT_SUM_W-1:0]              short_sum;
    logic                                above;
    logic                                onset;
  } onset_word_t;

  // Window sums, ratio compare and onset latch, plus the queue of awaited words
  class onset_scoreboard;
    logic [SAMPLE_BITS-1:0] ring [RING_DEPTH];
    int unsigned wr_ptr, fill, short_acc, long_acc;
    bit in_event;
    logic [SHORT_LEN_W-1:0] short_len;
    logic [LONG_LEN_W-1:0]  long_len;
    logic [THRESH_W-1:0]    threshold;
    onset_word_t awaited [$];
    int unsigned errors, checked, onsets, aboves;

    function new();
      // reset settings: 5 / 75 / 12.0
      short_len = 5'd5;
      long_len  = 8'd75;
      threshold = 12'd192;
      foreach (ring[i]) ring[i] = '0;
      restart();
      errors  = 0;
      checked = 0;
      onsets  = 0;
      aboves  = 0;
    endfunction

    function void restart();
      wr_ptr    = 0;
      fill      = 0;
      short_acc = 0;
      long_acc  = 0;
      in_event  = 1'b0;
    endfunction

    function int unsigned long_window();
      int unsigned l;
      l = long_len;
      if (l < 2) l = 2;
      if (l > RING_DEPTH) l = RING_DEPTH;
      return l;
    endfunction

    function int unsigned short_window();
      int unsigned s;
      s = short_len;
      if (s < 1) s = 1;
      if (s > SHORT_MAX) s = SHORT_MAX;
      if (s > long_window()) s = long_window();
      return s;
    endfunction

    // a length write starts both windows filling again
    function void write_reg(logic [CFG_ADDR_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SHORT_LEN: begin
          short_len = data[SHORT_LEN_W-1:0];
          restart();
        end
        REG_LONG_LEN: begin
          long_len = data[LONG_LEN_W-1:0];
          restart();
        end
        REG_THRESHOLD: threshold = data[THRESH_W-1:0];
        default: ;
      endcase
    endfunction

    function void note_sample(logic [SAMPLE_BITS-1:0] x);
      int unsigned l, s;
      longint unsigned lhs, rhs;
      onset_word_t w;
      l = long_window();
      s = short_window();
      if (fill >= s) short_acc -= ring[(wr_ptr + RING_DEPTH - s) % RING_DEPTH];
      if (fill >= l) long_acc -= ring[(wr_ptr + RING_DEPTH - l) % RING_DEPTH];
      ring[wr_ptr] = x;
      wr_ptr = (wr_ptr + 1) % RING_DEPTH;
      short_acc += x;
      long_acc  += x;
      if (fill < l) fill++;
      // still filling, or silent long window: no word, latch untouched
      if (fill < l || long_acc == 0) return;
      lhs = short_acc;
      lhs = lhs * l * 16;
      rhs = threshold;
      rhs = rhs * long_acc * s;
      w = '0;
      w.above = (lhs > rhs);
      if (w.above) begin
        w.onset  = !in_event;
        in_event = 1'b1;
      end else begin
        in_event = 1'b0;
      end
      w.short_sum = SHORT_SUM_W'(short_acc);
      w.long_sum  = LONG_SUM_W'(long_acc);
      awaited.insert(awaited.size(), w);
    endfunction

    function void check_word(logic [OUT_TDATA_W-1:0] raw);
      onset_word_t got, want;
      got = onset_word_t'(raw);
      if (awaited.size() == 0) begin
        errors++;
        if (errors <= SHOW_MAX) $display("unexpected result word %h", raw);
        return;
      end
      want = awaited.pop_front();
      checked++;
      onsets += want.onset;
      aboves += want.above;
      if (got.onset !== want.onset || got.above !== want.above ||
          got.short_sum !== want.short_sum || got.long_sum !== want.long_sum ||
          got.pad !== want.pad) begin
        errors++;
        if (errors <= SHOW_MAX)
          $display({"word %0d: expected onset %0b above %0b short %0d long %0d, ",
                    "got %0b %0b %0d %0d pad %h"},
                   checked, want.onset, want.above, want.short_sum, want.long_sum,
                   got.onset, got.above, got.short_sum, got.long_sum, got.pad);
      end
    endfunction

    function int unsigned pending();
      return awaited.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   cfg_we_i;
  logic [CFG_ADDR_W-1:0]  cfg_addr_i;
  logic [CFG_DATA_W-1:0]  cfg_wdata_i;
  logic                   s_tvalid_i;
  logic                   s_tready_o;
  logic [IN_TDATA_W-1:0]  s_tdata_i;     // sample
  logic                   m_tvalid_o;
  logic                   m_tready_i;
  logic [OUT_TDATA_W-1:0] m_tdata_o;     // onset, above_threshold, short_sum, long_sum

  onset_scoreboard sb = new();
  logic [SAMPLE_BITS-1:0] seq [$];
  bit          steady = 1'b0;
  bit          paused_once = 1'b0;
  int unsigned burst_left = 0;
  int unsigned zero_left = 0;
  int unsigned samples_sent = 0;
  int unsigned random_items = 0;
  int unsigned settings = 0;

  sta_lta_onset_detector uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o)
  );

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // receiver stalls at random, never during a steady phase
  always @(posedge clk_i) begin
    m_tready_i <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
  end

  // result word monitor
  always @(posedge clk_i) begin
    if (m_tvalid_o && m_tready_i) sb.check_word(m_tdata_o);
  end

  // watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk_i);
    $display("run stopped after %0d cycles with %0d words awaited", CYCLE_LIMIT, sb.pending());
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
  endtask

  // one sample word, after a random gap outside a steady phase
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] x);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      s_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= IN_TDATA_W'(x);
    do @(posedge clk_i); while (!s_tready_o);
    sb.note_sample(x);
    samples_sent++;
  endtask

  // stop sending until every awaited word is in and the block has settled
  task automatic drain();
    s_tvalid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  // quiet background with bursts, runs of zeros and the odd full-range sample
  function automatic logic [SAMPLE_BITS-1:0] pick_sample();
    int unsigned r;
    if (burst_left != 0) begin
      burst_left--;
      return SAMPLE_BITS'($urandom_range(200, 1023));
    end
    if (zero_left != 0) begin
      zero_left--;
      return '0;
    end
    r = $urandom_range(0, 99);
    if (r < 5) burst_left = $urandom_range(2, 12);
    else if (r < 9) zero_left = $urandom_range(2, 48);
    if (r < 15) return SAMPLE_BITS'($urandom_range(0, 1023));
    return SAMPLE_BITS'($urandom_range(0, 40));
  endfunction

  // settings from seq's test case, then its samples
  task automatic run_directed(input logic [CFG_DATA_W-1:0] short_d, long_d, thr_d);
    write_reg(REG_SHORT_LEN, short_d);
    write_reg(REG_LONG_LEN, long_d);
    write_reg(REG_THRESHOLD, thr_d);
    write_reg(REG_UNUSED, '1);
    cfg_we_i <= 1'b0;
    settings++;
    foreach (seq[i]) send_sample(seq[i]);
    drain();
  endtask

  // kind 0: keep settings, 1: threshold only (windows run on), 2: all registers
  task automatic random_phase(input int unsigned kind);
    int unsigned n, r, v;
    bit pause;
    if (kind == 2) begin
      r = $urandom_range(0, 9);
      v = (r == 0) ? 0 : (r == 1) ? 16 :
          (r == 2) ? $urandom_range(17, 31) : $urandom_range(1, 16);
      write_reg(REG_SHORT_LEN, {7'($urandom), 5'(v)});
      r = $urandom_range(0, 9);
      v = (r == 0) ? $urandom_range(0, 1) : (r == 1) ? 128 :
          (r == 2) ? $urandom_range(129, 255) : (r == 3) ? $urandom_range(41, 127) :
          $urandom_range(2, 40);
      write_reg(REG_LONG_LEN, {4'($urandom), 8'(v)});
    end
    if (kind != 0) begin
      r = $urandom_range(0, 9);
      v = (r == 0) ? 0 : (r == 1) ? 4095 : (r == 2) ? $urandom_range(0, 4095) :
          $urandom_range(16, 320);
      write_reg(REG_THRESHOLD, CFG_DATA_W'(v));
      if ($urandom_range(0, 2) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom));
      cfg_we_i <= 1'b0;
    end
    settings++;
    n = $urandom_range(20, 60) + ((kind == 1) ? 0 : sb.long_window());
    pause = !paused_once || ($urandom_range(0, 3) == 0);
    paused_once = 1'b1;
    for (int unsigned i = 0; i < n; i++) begin
      if (pause && i == n / 2) drain();
      send_sample(pick_sample());
    end
    random_items += n;
    drain();
  endtask

  initial begin
    rst_ni      = 1'b0;
    cfg_we_i    = 1'b0;
    cfg_addr_i  = '0;
    cfg_wdata_i = '0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = '0;
    m_tready_i  = 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // settings out of reset first, since any write changes them
    random_phase(0);

    // both lengths below range: windows of 1 and 2, zero threshold, silent start
    seq = '{10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd1};
    run_directed(12'h000, 12'h000, 12'd0);
    // top threshold, full-scale samples
    seq = '{10'd1023, 10'd1023, 10'd1023};
    run_directed(12'h002, 12'h002, 12'd4095);
    // latch held over a silent long window
    seq = '{10'd1023, 10'd1023, 10'd0, 10'd0, 10'd7};
    run_directed(12'h002, 12'h002, 12'd8);
    // short length above range clamped to the long one; ratio exactly at threshold
    seq = '{10'd1023, 10'd0, 10'd0, 10'd1023, 10'd500};
    run_directed(12'hFF4, 12'hF03, 12'd16);

    while (random_items < RANDOM_ITEMS) begin
      steady = (settings == 8);
      random_phase(($urandom_range(0, 3) == 0) ? 1 : 2);
    end
    steady = 1'b0;

    $display("Sent %0d samples under %0d window/threshold settings, clamped lengths included.",
             samples_sent, settings);
    $display("Checked %0d result words (%0d above threshold, %0d onsets), %0d mismatches.",
             sb.checked, sb.aboves, sb.onsets, sb.errors);
    if (sb.pending() != 0) $display("%0d result words never arrived", sb.pending());
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
